// ===== rtl/plm_pkg.sv =====
package plm_pkg;

    localparam int THR_BITS     = 11;
    localparam int CFG_IDX_BITS = 1;

    // Fractional bits of the log2 and the Q28 scale factor 20*log10(2).
    localparam int LOG_FRAC = 24;
    localparam int EXP_W    = 5;
    localparam int K_BITS   = 31;
    localparam int K_FRAC   = 28;
    localparam logic [K_BITS-1:0] K_Q28 = 31'd1616142483;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TALK  = 1'b0,
        REG_SHOUT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CLS_SILENT = 2'd0,
        CLS_TALK   = 2'd1,
        CLS_SHOUT  = 2'd2
    } t_voice_class;

    function automatic int f_level_bits(input int frac_bits);
        return $clog2(100 * (2 ** frac_bits) + 1) + 1;
    endfunction

endpackage

// ===== rtl/plm_front.sv =====
module plm_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last_in_block,
    input  logic                          i_muted,
    input  logic                          i_q_full,
    output logic                          o_push,
    output logic [SAMPLE_BITS-1:0]        o_push_peak,
    output logic                          o_push_muted
);
    import plm_pkg::*;

    logic [SAMPLE_BITS-1:0] r_peak;
    logic [SAMPLE_BITS-1:0] n_peak;
    logic [SAMPLE_BITS-1:0] w_raw;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [SAMPLE_BITS-1:0] w_max;
    logic                   w_accept;

    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;

    assign w_raw = i_sample;
    assign w_mag = w_raw[SAMPLE_BITS-1] ? (~w_raw + 1'b1) : w_raw;
    assign w_max = (w_mag > r_peak) ? w_mag : r_peak;

    assign o_push       = w_accept && i_last_in_block;
    assign o_push_peak  = w_max;
    assign o_push_muted = i_muted;

    always_comb begin
        n_peak = r_peak;
        if (w_accept) begin
            n_peak = i_last_in_block ? '0 : w_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else begin
            r_peak <= n_peak;
        end
    end

    a_peak_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_peak == '0)
        else $error("running peak not cleared after a block ended");

endmodule

// ===== rtl/plm_queue.sv =====
module plm_queue #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_vld,
    output logic [WIDTH-1:0] o_data
);
    import plm_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    n_rd;
    logic [CNT_W-1:0] n_cnt;

    assign o_full = (r_cnt == CNT_W'(DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_data = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> i_pop)
        else $error("block queue written while full");

endmodule

// ===== rtl/plm_back.sv =====
module plm_back #(
    parameter int SAMPLE_BITS  = 16,
    parameter int DB_FRAC_BITS = 4
) (
    input  logic                                                     i_clk,
    input  logic                                                     i_rst_n,
    input  logic                                                     i_cfg_we,
    input  logic [plm_pkg::CFG_IDX_BITS-1:0]                         i_cfg_idx,
    input  logic [plm_pkg::THR_BITS-1:0]                             i_cfg_data,
    input  logic                                                     i_q_vld,
    input  logic [SAMPLE_BITS-1:0]                                   i_q_peak,
    input  logic                                                     i_q_muted,
    output logic                                                     o_q_pop,
    output logic                                                     o_out_valid,
    input  logic                                                     i_out_stall,
    output logic signed [plm_pkg::f_level_bits(DB_FRAC_BITS)-1:0]    o_level_db,
    output logic [1:0]                                               o_voice_class
);
    import plm_pkg::*;

    localparam int LW        = f_level_bits(DB_FRAC_BITS);
    localparam int NW        = $clog2(SAMPLE_BITS);
    localparam int CW        = (LW > THR_BITS) ? LW : THR_BITS;
    localparam int MAG_W     = EXP_W + LOG_FRAC;
    localparam int PROD_W    = MAG_W + K_BITS;
    localparam int RND_SH    = LOG_FRAC + K_FRAC - DB_FRAC_BITS;
    localparam int LVL_W     = PROD_W + 1 - RND_SH;
    localparam int FLOOR_MAG = 100 * (2 ** DB_FRAC_BITS);
    localparam int DECAY     = 2 * (2 ** DB_FRAC_BITS);
    localparam int LAST      = LOG_FRAC - 1;
    localparam logic signed [LW-1:0] FLOOR_LVL = LW'(-FLOOR_MAG);
    localparam logic [SAMPLE_BITS-1:0] QUIET_MAX =
        SAMPLE_BITS'((2 ** (SAMPLE_BITS - 1)) / 100000);
    localparam logic [PROD_W:0] RND_HALF = {{PROD_W{1'b0}}, 1'b1} << (RND_SH - 1);

    logic w_en;

    logic signed [THR_BITS-1:0] r_talk;
    logic signed [THR_BITS-1:0] r_shout;

    // Normalize stage.
    logic [NW-1:0] w_lead;
    logic [31:0]   w_norm;
    logic          r_p_vld;
    logic [31:0]   r_p_m;
    logic [NW-1:0] r_p_n;
    logic          r_p_mute;
    logic          r_p_quiet;

    // Squaring stages, one fractional log2 bit each.
    logic                r_sq_vld   [LOG_FRAC];
    logic [31:0]         r_sq_m     [LOG_FRAC];
    logic [LOG_FRAC-1:0] r_sq_frac  [LOG_FRAC];
    logic [NW-1:0]       r_sq_n     [LOG_FRAC];
    logic                r_sq_mute  [LOG_FRAC];
    logic                r_sq_quiet [LOG_FRAC];
    logic                n_sq_vld   [LOG_FRAC];
    logic [31:0]         n_sq_m     [LOG_FRAC];
    logic [LOG_FRAC-1:0] n_sq_frac  [LOG_FRAC];
    logic [NW-1:0]       n_sq_n     [LOG_FRAC];
    logic                n_sq_mute  [LOG_FRAC];
    logic                n_sq_quiet [LOG_FRAC];

    // Scale stage.
    logic [EXP_W-1:0]  w_exp;
    logic [MAG_W-1:0]  w_mag;
    logic [PROD_W-1:0] w_prod;
    logic              r_mul_vld;
    logic [PROD_W-1:0] r_mul_prod;
    logic              r_mul_mute;
    logic              r_mul_quiet;

    // Rounding stage.
    logic [PROD_W:0]       w_sum;
    logic [LVL_W-1:0]      w_lvl;
    logic signed [LW-1:0]  n_lvl;
    logic                  r_lvl_vld;
    logic signed [LW-1:0]  r_lvl;
    logic                  r_lvl_mute;

    // Hold, decay and classification.
    logic signed [LW-1:0]  r_held;
    logic signed [LW-1:0]  n_held;
    logic signed [LW:0]    w_dec;
    logic signed [CW-1:0]  w_held_c;
    t_voice_class          n_cls;

    logic                  r_out_vld;
    logic signed [LW-1:0]  r_out_lvl;
    t_voice_class          r_out_cls;

    assign w_en    = !r_out_vld || !i_out_stall;
    assign o_q_pop = w_en && i_q_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_talk  <= '0;
            r_shout <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TALK:  r_talk  <= i_cfg_data;
                REG_SHOUT: r_shout <= i_cfg_data;
                default:   r_talk  <= r_talk;
            endcase
        end
    end

    always_comb begin
        w_lead = '0;
        for (int i = 0; i < SAMPLE_BITS; i++) begin
            if (i_q_peak[i]) begin
                w_lead = NW'(i);
            end
        end
    end

    assign w_norm = 32'(i_q_peak) << (5'd31 - 5'(w_lead));

    for (genvar gi = 0; gi < LOG_FRAC; gi++) begin : g_sq
        logic [31:0]         w_src_m;
        logic [LOG_FRAC-1:0] w_src_frac;
        logic [63:0]         w_sq;
        logic [32:0]         w_top;
        if (gi == 0) begin : g_first
            assign w_src_m        = r_p_m;
            assign w_src_frac     = '0;
            assign n_sq_vld[gi]   = r_p_vld;
            assign n_sq_n[gi]     = r_p_n;
            assign n_sq_mute[gi]  = r_p_mute;
            assign n_sq_quiet[gi] = r_p_quiet;
        end else begin : g_next
            assign w_src_m        = r_sq_m[gi-1];
            assign w_src_frac     = r_sq_frac[gi-1];
            assign n_sq_vld[gi]   = r_sq_vld[gi-1];
            assign n_sq_n[gi]     = r_sq_n[gi-1];
            assign n_sq_mute[gi]  = r_sq_mute[gi-1];
            assign n_sq_quiet[gi] = r_sq_quiet[gi-1];
        end
        assign w_sq          = w_src_m * w_src_m;
        assign w_top         = w_sq[63:31];
        assign n_sq_m[gi]    = w_top[32] ? w_top[32:1] : w_top[31:0];
        assign n_sq_frac[gi] = {w_src_frac[LOG_FRAC-2:0], w_top[32]};
    end

    assign w_exp  = EXP_W'(SAMPLE_BITS - 1) - EXP_W'(r_sq_n[LAST]);
    assign w_mag  = {w_exp, {LOG_FRAC{1'b0}}} - {{EXP_W{1'b0}}, r_sq_frac[LAST]};
    assign w_prod = w_mag * K_Q28;

    assign w_sum = {1'b0, r_mul_prod} + RND_HALF;
    assign w_lvl = w_sum[PROD_W:RND_SH];

    always_comb begin
        if (r_mul_quiet || (w_lvl > LVL_W'(FLOOR_MAG))) begin
            n_lvl = FLOOR_LVL;
        end else begin
            n_lvl = LW'(0) - LW'(w_lvl);
        end
    end

    assign w_dec = (LW+1)'(r_held) - (LW+1)'(DECAY);

    always_comb begin
        priority if (r_lvl_mute) begin
            n_held = FLOOR_LVL;
        end else if (r_lvl > r_held) begin
            n_held = r_lvl;
        end else if (w_dec < (LW+1)'(FLOOR_LVL)) begin
            n_held = FLOOR_LVL;
        end else begin
            n_held = LW'(w_dec);
        end
    end

    assign w_held_c = CW'(n_held);

    always_comb begin
        priority if (w_held_c >= CW'(r_shout)) begin
            n_cls = CLS_SHOUT;
        end else if (w_held_c >= CW'(r_talk)) begin
            n_cls = CLS_TALK;
        end else begin
            n_cls = CLS_SILENT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld   <= 1'b0;
            r_mul_vld <= 1'b0;
            r_lvl_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_held    <= FLOOR_LVL;
            for (int i = 0; i < LOG_FRAC; i++) begin
                r_sq_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_p_vld   <= i_q_vld;
            r_mul_vld <= r_sq_vld[LAST];
            r_lvl_vld <= r_mul_vld;
            r_out_vld <= r_lvl_vld;
            if (r_lvl_vld) begin
                r_held <= n_held;
            end
            for (int i = 0; i < LOG_FRAC; i++) begin
                r_sq_vld[i] <= n_sq_vld[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_m       <= w_norm;
            r_p_n       <= w_lead;
            r_p_mute    <= i_q_muted;
            r_p_quiet   <= (i_q_peak <= QUIET_MAX);
            for (int i = 0; i < LOG_FRAC; i++) begin
                r_sq_m[i]     <= n_sq_m[i];
                r_sq_frac[i]  <= n_sq_frac[i];
                r_sq_n[i]     <= n_sq_n[i];
                r_sq_mute[i]  <= n_sq_mute[i];
                r_sq_quiet[i] <= n_sq_quiet[i];
            end
            r_mul_prod  <= w_prod;
            r_mul_mute  <= r_sq_mute[LAST];
            r_mul_quiet <= r_sq_quiet[LAST];
            r_lvl       <= n_lvl;
            r_lvl_mute  <= r_mul_mute;
            r_out_lvl   <= n_held;
            r_out_cls   <= n_cls;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_level_db    = r_out_lvl;
    assign o_voice_class = r_out_cls;

    a_held_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held >= FLOOR_LVL)
        else $error("held level fell below the floor");

    a_mute_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_lvl_vld && r_lvl_mute) |=> r_held == FLOOR_LVL)
        else $error("muted block did not force the floor");

    a_shout_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_cls == CLS_SHOUT) |-> CW'(r_out_lvl) >= CW'(r_shout))
        else $error("shouting class below shouting threshold");

endmodule

// ===== rtl/peak_level_meter_db_classifier_unit.sv =====
// Channel  | Direction | Handshake                | Payload
// samples  | in        | i_in_valid / o_in_stall  | i_sample, i_last_in_block, i_muted
// levels   | out       | o_out_valid / i_out_stall| o_level_db, o_voice_class
// config   | in        | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// One sample is taken every cycle while the input is not stalled; a block's
// result passes through the block queue, the normalize stage, the 24-stage log2
// squaring pipeline, and the scale, round and hold stages.
// Reset is synchronous: held level at -100 dB, thresholds 0.
// An output stall freezes the level pipeline; a 4-entry block queue keeps the
// sample side running until it fills, and only then is the input stalled.
module peak_level_meter_db_classifier_unit #(
    parameter int SAMPLE_BITS  = 16,
    parameter int DB_FRAC_BITS = 4
) (
    input  logic                                                     i_clk,
    input  logic                                                     i_rst_n,
    input  logic                                                     i_in_valid,
    output logic                                                     o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]                            i_sample,
    input  logic                                                     i_last_in_block,
    input  logic                                                     i_muted,
    output logic                                                     o_out_valid,
    input  logic                                                     i_out_stall,
    output logic signed [plm_pkg::f_level_bits(DB_FRAC_BITS)-1:0]    o_level_db,
    output logic [1:0]                                               o_voice_class,
    input  logic                                                     i_cfg_we,
    input  logic [plm_pkg::CFG_IDX_BITS-1:0]                         i_cfg_idx,
    input  logic [plm_pkg::THR_BITS-1:0]                             i_cfg_data
);
    import plm_pkg::*;

    localparam int QW = SAMPLE_BITS + 1;

    logic                   w_push;
    logic [SAMPLE_BITS-1:0] w_push_peak;
    logic                   w_push_muted;
    logic                   w_q_full;
    logic                   w_q_vld;
    logic                   w_q_pop;
    logic [QW-1:0]          w_q_data;

    plm_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_last_in_block(i_last_in_block),
        .i_muted        (i_muted),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_push_peak    (w_push_peak),
        .o_push_muted   (w_push_muted)
    );

    plm_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data ({w_push_peak, w_push_muted}),
        .o_full (w_q_full),
        .i_pop  (w_q_pop),
        .o_vld  (w_q_vld),
        .o_data (w_q_data)
    );

    plm_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DB_FRAC_BITS(DB_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_q_vld      (w_q_vld),
        .i_q_peak     (w_q_data[QW-1:1]),
        .i_q_muted    (w_q_data[0]),
        .o_q_pop      (w_q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_level_db   (o_level_db),
        .o_voice_class(o_voice_class)
    );

endmodule

// ===== verif/plm_checker.sv =====
module plm_checker #(
    parameter int SAMPLE_W = 16,
    parameter int DB_FRAC  = 4
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_in_valid,
    input  logic                                               i_in_stall,
    input  logic signed [SAMPLE_W-1:0]                         i_sample,
    input  logic                                               i_last_in_block,
    input  logic                                               i_muted,
    input  logic                                               i_out_valid,
    input  logic                                               i_out_stall,
    input  logic signed [plm_pkg::f_level_bits(DB_FRAC)-1:0]   i_level_db,
    input  logic [1:0]                                         i_voice_class,
    input  logic                                               i_cfg_we,
    input  logic [plm_pkg::CFG_IDX_BITS-1:0]                   i_cfg_idx,
    input  logic [plm_pkg::THR_BITS-1:0]                       i_cfg_data,
    output int                                                 o_errors,
    output int                                                 o_pending,
    output int                                                 o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import plm_pkg::*;

    localparam int LEVEL_W     = f_level_bits(DB_FRAC);
    localparam int FLOOR_DB    = -100 * (2 ** DB_FRAC);
    localparam int DECAY_DB    = 2 * (2 ** DB_FRAC);
    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic signed [LEVEL_W-1:0] level;
        t_voice_class              cls;
    } level_result_t;

    level_result_t             level_fifo[$];
    int                        talk_thr;
    int                        shout_thr;
    int                        held_level;
    logic [SAMPLE_W-1:0]       block_peak;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
    end

    task automatic report(input string what);
        o_errors++;
        if (o_errors <= MAX_PRINTED) begin
            $display("[%0t] ERROR: %s", $realtime, what);
        end
    endtask

    // Log level of a nonzero peak in 1/16 dB, from a bit-serial log2 of the peak.
    function automatic int level_of_peak(input logic [SAMPLE_W-1:0] pk);
        int          msb;
        logic [63:0] mant;
        logic [63:0] frac;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] rounded;
        msb = 0;
        for (int b = 0; b < SAMPLE_W; b++) begin
            if (pk[b]) begin
                msb = b;
            end
        end
        mant = 64'(pk) << (31 - msb);
        frac = '0;
        for (int b = LOG_FRAC - 1; b >= 0; b--) begin
            mant = (mant * mant) >> 31;
            if (mant >= 64'h1_0000_0000) begin
                mant    = mant >> 1;
                frac[b] = 1'b1;
            end
        end
        if (msb >= SAMPLE_W - 1) begin
            return 0;
        end
        mag     = (64'(SAMPLE_W - 1 - msb) << LOG_FRAC) - frac;
        prod    = mag * 64'(K_Q28);
        rounded = (prod + (64'd1 << (51 - DB_FRAC))) >> (52 - DB_FRAC);
        if (rounded > 64'(-FLOOR_DB)) begin
            return FLOOR_DB;
        end
        return -int'(rounded);
    endfunction

    task automatic predict_beat(input logic signed [SAMPLE_W-1:0] smp, input logic last,
                                input logic mute);
        logic [SAMPLE_W-1:0] mag;
        int                  new_level;
        level_result_t       res;
        mag = smp[SAMPLE_W-1] ? SAMPLE_W'(-smp) : SAMPLE_W'(smp);
        if (mag > block_peak) begin
            block_peak = mag;
        end
        if (!last) begin
            return;
        end
        if (mute) begin
            held_level = FLOOR_DB;
        end else begin
            if (64'(block_peak) * 64'd100000 > (64'd1 << (SAMPLE_W - 1))) begin
                new_level = level_of_peak(block_peak);
            end else begin
                new_level = FLOOR_DB;
            end
            if (new_level > held_level) begin
                held_level = new_level;
            end else begin
                held_level = held_level - DECAY_DB;
                if (held_level < FLOOR_DB) begin
                    held_level = FLOOR_DB;
                end
            end
        end
        block_peak = '0;
        res.level  = LEVEL_W'(held_level);
        if (held_level >= shout_thr) begin
            res.cls = CLS_SHOUT;
        end else if (held_level >= talk_thr) begin
            res.cls = CLS_TALK;
        end else begin
            res.cls = CLS_SILENT;
        end
        level_fifo.push_back(res);
    endtask

    always @(posedge i_clk) begin : monitor
        level_result_t want;
        if (!i_rst_n) begin
            talk_thr   = 0;
            shout_thr  = 0;
            held_level = FLOOR_DB;
            block_peak = '0;
            level_fifo.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TALK: begin
                        talk_thr = int'($signed(i_cfg_data));
                    end
                    REG_SHOUT: begin
                        shout_thr = int'($signed(i_cfg_data));
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (level_fifo.size() == 0) begin
                    report($sformatf("level beat with no result pending: level %0d class %0d",
                                     i_level_db, i_voice_class));
                end else begin
                    want = level_fifo.pop_front();
                    if (i_level_db !== want.level) begin
                        report($sformatf("level_db got %0d, predicted %0d",
                                         i_level_db, want.level));
                    end
                    if (i_voice_class !== want.cls) begin
                        report($sformatf("voice_class got %0d, predicted %0d (level %0d)",
                                         i_voice_class, want.cls, want.level));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_beat(i_sample, i_last_in_block, i_muted);
            end
        end
        o_pending <= level_fifo.size();
    end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plm_pkg::*;

    localparam int SAMPLE_W     = 16;
    localparam int DB_FRAC      = 4;
    localparam int LEVEL_W      = f_level_bits(DB_FRAC);
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_BEATS  = 100;
    localparam int NUM_PHASES   = 7;
    localparam int CYCLE_LIMIT  = 400000;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_in_valid      = 1'b0;
    logic                          o_in_stall;
    logic signed [SAMPLE_W-1:0]    i_sample        = '0;
    logic                          i_last_in_block = 1'b0;
    logic                          i_muted         = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall     = 1'b0;
    logic signed [LEVEL_W-1:0]     o_level_db;
    logic [1:0]                    o_voice_class;
    logic                          i_cfg_we        = 1'b0;
    logic [CFG_IDX_BITS-1:0]       i_cfg_idx       = '0;
    logic [THR_BITS-1:0]           i_cfg_data      = '0;

    int errors;
    int pending;
    int results;
    int beats_sent     = 0;
    int settings_used  = 1;
    int cycles         = 0;
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;

    always #1 i_clk = ~i_clk;

    peak_level_meter_db_classifier_unit #(
        .SAMPLE_BITS  (SAMPLE_W),
        .DB_FRAC_BITS (DB_FRAC)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample        (i_sample),
        .i_last_in_block (i_last_in_block),
        .i_muted         (i_muted),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_level_db      (o_level_db),
        .o_voice_class   (o_voice_class),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    plm_checker #(
        .SAMPLE_W (SAMPLE_W),
        .DB_FRAC  (DB_FRAC)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_sample        (i_sample),
        .i_last_in_block (i_last_in_block),
        .i_muted         (i_muted),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_level_db      (o_level_db),
        .i_voice_class   (o_voice_class),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_results       (results)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results pending.", cycles, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    initial begin : level_stall_gen
        int n;
        forever begin
            n = pick_gap();
            if (receiver_idles && n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    task automatic send_beat(input logic signed [SAMPLE_W-1:0] smp, input logic last,
                             input logic mute);
        int n;
        i_in_valid      <= 1'b1;
        i_sample        <= smp;
        i_last_in_block <= last;
        i_muted         <= mute;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        beats_sent++;
        n = pick_gap();
        if (sender_idles && n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold off the sample side until every block result has come back.
    task automatic drain_levels();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_thresholds(input int talk, input int shout);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_TALK;
        i_cfg_data <= THR_BITS'(talk);
        @(posedge i_clk);
        i_cfg_idx  <= REG_SHOUT;
        i_cfg_data <= THR_BITS'(shout);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample(input int shift);
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 15))
            0: s = {1'b1, {(SAMPLE_W-1){1'b0}}};
            1: s = {1'b0, {(SAMPLE_W-1){1'b1}}};
            default: s = $signed(SAMPLE_W'($urandom)) >>> shift;
        endcase
        return s;
    endfunction

    task automatic random_block();
        int len;
        int shift;
        bit silent;
        len    = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        silent = ($urandom_range(0, 7) == 0);
        shift  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, SAMPLE_W - 1);
        for (int k = 0; k < len; k++) begin
            send_beat(silent ? '0 : rand_sample(shift), k == len - 1,
                      (k == len - 1) ? ($urandom_range(0, 9) == 0)
                                     : 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : stimulus
        int talk_set[NUM_PHASES];
        int shout_set[NUM_PHASES];
        int start;
        bit paused;
        talk_set  = '{0, -960, -480, -1024, 0, 0, -200};
        shout_set = '{0, 0, -96, 1023, -960, 0, -200};
        talk_set[5]  = int'($signed(THR_BITS'($urandom)));
        shout_set[5] = int'($signed(THR_BITS'($urandom)));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed blocks under the reset thresholds.
        send_beat(16'sd0, 1'b1, 1'b0);
        send_beat(16'sd1, 1'b1, 1'b0);
        send_beat(-16'sd1, 1'b1, 1'b0);
        send_beat(16'sh7fff, 1'b1, 1'b0);
        send_beat(16'sh8000, 1'b1, 1'b0);
        send_beat(16'sd100, 1'b0, 1'b1);
        send_beat(-16'sd5000, 1'b0, 1'b0);
        send_beat(16'sh4000, 1'b0, 1'b1);
        send_beat(16'sd3, 1'b1, 1'b0);
        send_beat(16'sh7fff, 1'b0, 1'b0);
        send_beat(16'sd5, 1'b1, 1'b1);
        send_beat(16'sd0, 1'b0, 1'b1);
        send_beat(16'sd0, 1'b1, 1'b0);
        send_beat(16'sd0, 1'b1, 1'b0);
        send_beat(16'sh7fff, 1'b0, 1'b1);
        send_beat(16'sd1, 1'b1, 1'b0);
        send_beat(16'sh8001, 1'b1, 1'b0);
        send_beat(16'sh0200, 1'b1, 1'b0);
        send_beat(16'sd0, 1'b1, 1'b1);
        send_beat(-16'sd32, 1'b1, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_levels();
            if (p > 0) begin
                write_thresholds(talk_set[p], shout_set[p]);
            end
            sender_idles   = (p != 2);
            receiver_idles = (p != 2);
            start  = beats_sent;
            paused = 1'b0;
            while (beats_sent - start < PHASE_BEATS) begin
                random_block();
                if (p == 4 && !paused && beats_sent - start >= PHASE_BEATS / 2) begin
                    drain_levels();
                    paused = 1'b1;
                end
            end
        end

        drain_levels();
        $display("Sent %0d sample beats and checked %0d level results.", beats_sent, results);
        $display("Threshold settings exercised: %0d, including range and pattern extremes.",
                 settings_used);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
